// File: rtl/m3_pkg.sv
// ----------------------------------------------------------------------------
// m3_pkg
// Shared widths, codes, structs and helpers for the 3x3 matrix block.
// ----------------------------------------------------------------------------
package m3_pkg;

  localparam int VW     = 32;          // value width, signed fixed point
  localparam int FB     = 16;          // fraction bits
  localparam int IW     = 4;           // element index width
  localparam int MW     = 2;           // mode width
  localparam int NELEM  = 9;
  localparam int MULW   = VW + 1;      // multiplier operand width
  localparam int PW     = 2 * MULW;    // multiplier product width
  localparam int KW     = 2 * VW + 1;  // cofactor width
  localparam int ACCW   = 3 * VW + 3;  // accumulator and divider width
  localparam int SW     = ACCW + 1;    // width ahead of saturation

  typedef logic [IW-1:0] idx_t;

  localparam idx_t LAST_IDX = idx_t'(NELEM - 1);

  typedef enum logic [MW-1:0] {
    MODE_ADD  = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_INV  = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef struct packed {
    logic          en;
    idx_t          idx;
    logic [VW-1:0] a;
    logic [VW-1:0] b;
  } wr_t;

  typedef struct packed {
    idx_t a0;
    idx_t a1;
    idx_t b;
  } rd_addr_t;

  typedef struct packed {
    logic [VW-1:0] a0;
    logic [VW-1:0] a1;
    logic [VW-1:0] b;
  } rd_data_t;

  typedef struct packed {
    logic                   start;
    logic signed [ACCW-1:0] num;
    logic signed [ACCW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [ACCW-1:0] q_mag;
    logic            neg;
  } div_rsp_t;

  typedef struct packed {
    idx_t          idx;
    logic [VW-1:0] value;
    logic          singular;
    logic          last;
  } res_t;

  // adjugate entry n = A[x]*A[y] - A[z]*A[w], as {x, y, z, w}
  localparam idx_t ADJ [NELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  function automatic idx_t times3(input logic [1:0] k);
    unique case (k)
      2'd0:    return idx_t'(0);
      2'd1:    return idx_t'(3);
      2'd2:    return idx_t'(6);
      default: return idx_t'(0);
    endcase
  endfunction

  function automatic idx_t row_base(input idx_t i);
    if (i < idx_t'(3)) return idx_t'(0);
    else if (i < idx_t'(6)) return idx_t'(3);
    else return idx_t'(6);
  endfunction

  function automatic logic [1:0] col_of(input idx_t i);
    unique case (i)
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      4'd2, 4'd5, 4'd8: return 2'd2;
      default:          return 2'd0;
    endcase
  endfunction

  // Clamp a wide signed value to the value width.
  function automatic logic [VW-1:0] sat_val(input logic signed [SW-1:0] v);
    if (v[SW-1:VW-1] == '0 || v[SW-1:VW-1] == '1) return v[VW-1:0];
    else if (v[SW-1]) return {1'b1, {(VW-1){1'b0}}};
    else return {1'b0, {(VW-1){1'b1}}};
  endfunction

endpackage

// File: rtl/m3_if.sv
// ----------------------------------------------------------------------------
// m3_in_if / m3_out_if
// Valid/ready channels for element loads and result elements.
// ----------------------------------------------------------------------------
interface m3_in_if;
  import m3_pkg::*;
  logic          valid;
  logic          ready;
  logic [MW-1:0] mode;
  logic [IW-1:0] elem_index;
  logic [VW-1:0] a_elem;
  logic [VW-1:0] b_elem;
  modport source (output valid, mode, elem_index, a_elem, b_elem, input ready);
  modport sink   (input valid, mode, elem_index, a_elem, b_elem, output ready);
endinterface

interface m3_out_if;
  import m3_pkg::*;
  logic          valid;
  logic          ready;
  logic [IW-1:0] out_index;
  logic [VW-1:0] out_value;
  logic          singular;
  logic          last_out;
  modport source (output valid, out_index, out_value, singular, last_out, input ready);
  modport sink   (input valid, out_index, out_value, singular, last_out, output ready);
endinterface

// File: rtl/m3_store.sv
// ----------------------------------------------------------------------------
// m3_store
// Element memories for A (two read ports) and B (one read port).
// ----------------------------------------------------------------------------
module m3_store (
  input  logic             clk,
  input  m3_pkg::wr_t      wr,
  input  m3_pkg::rd_addr_t addr,
  output m3_pkg::rd_data_t data
);
  import m3_pkg::*;

  logic [VW-1:0] mem_a [NELEM];
  logic [VW-1:0] mem_b [NELEM];

  // write on load, registered reads
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_a[wr.idx] <= wr.a;
      mem_b[wr.idx] <= wr.b;
    end
    data.a0 <= mem_a[addr.a0];
    data.a1 <= mem_a[addr.a1];
    data.b  <= mem_b[addr.b];
  end

endmodule

// File: rtl/m3_div.sv
// ----------------------------------------------------------------------------
// m3_div
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module m3_div (
  input  logic             clk,
  input  logic             rst_n,
  input  m3_pkg::div_req_t req,
  output m3_pkg::div_rsp_t rsp
);
  import m3_pkg::*;

  localparam int CW = $clog2(ACCW);

  logic            busy_r;
  logic [CW-1:0]   cnt_r;
  logic [ACCW-1:0] n_r;
  logic [ACCW-1:0] d_r;
  logic [ACCW:0]   rem_r;
  logic [ACCW-1:0] q_r;
  logic            neg_r;
  logic            done_r;
  logic [ACCW:0]   rem_sh;
  logic            ge;

  // shift in the next numerator bit and trial subtract
  always_comb begin
    rem_sh = {rem_r[ACCW-1:0], n_r[ACCW-1]};
    ge     = rem_sh >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        q_r    <= '0;
        n_r    <= req.num[ACCW-1] ? ACCW'(-req.num) : req.num;
        d_r    <= req.den[ACCW-1] ? ACCW'(-req.den) : req.den;
        neg_r  <= req.num[ACCW-1] ^ req.den[ACCW-1];
      end else if (busy_r) begin
        rem_r <= ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
        q_r   <= {q_r[ACCW-2:0], ge};
        n_r   <= {n_r[ACCW-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ACCW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.q_mag = q_r;
  assign rsp.neg   = neg_r;

endmodule

// File: rtl/m3_engine.sv
// ----------------------------------------------------------------------------
// m3_engine
// Sequencer: reads the element memories, runs the shared multiplier and
// accumulator, keeps cofactors in a scratch memory and emits results.
// ----------------------------------------------------------------------------
module m3_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  m3_pkg::mode_t    mode,
  output logic             idle,
  output m3_pkg::rd_addr_t rd_addr,
  input  m3_pkg::rd_data_t rd_data,
  output m3_pkg::div_req_t div_req,
  input  m3_pkg::div_rsp_t div_rsp,
  output logic             out_valid,
  input  logic             out_ready,
  output m3_pkg::res_t     out_res
);
  import m3_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_FIN, S_DIV, S_DWAIT, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_ADD, PH_MUL, PH_COF, PH_DET, PH_DIV, PH_ZERO
  } phase_t;

  localparam logic [2:0] K_MUL_LAST = 3'd2;
  localparam logic [2:0] K_COF_LAST = 3'd1;
  localparam logic [2:0] K_DET_LAST = 3'd5;

  state_t                 state_r;
  phase_t                 ph_r;
  idx_t                   i_r;
  logic [2:0]             k_r;
  logic signed [ACCW-1:0] acc_r;
  logic signed [PW-1:0]   prod_r;
  logic signed [ACCW-1:0] det_r;
  logic [VW-1:0]          val_r;
  logic                   sing_r;
  logic                   out_valid_r;
  res_t                   out_r;

  logic signed [KW-1:0]   kf_mem [NELEM];
  logic signed [KW-1:0]   kf_rd_r;
  idx_t                   kf_addr;
  logic                   kf_we;

  logic signed [MULW-1:0] mul_x;
  logic signed [MULW-1:0] mul_y;
  logic signed [PW-1:0]   prod;
  logic signed [ACCW-1:0] term;
  logic signed [SW-1:0]   add_sum;
  logic signed [SW-1:0]   div_q;
  logic                   last_k;

  // operand addresses follow phase, element and term
  always_comb begin
    rd_addr = '0;
    kf_addr = i_r;
    unique case (ph_r)
      PH_ADD: begin
        rd_addr.a0 = i_r;
        rd_addr.b  = i_r;
      end
      PH_MUL: begin
        rd_addr.a0 = row_base(i_r) + idx_t'(k_r);
        rd_addr.b  = times3(k_r[1:0]) + idx_t'(col_of(i_r));
      end
      PH_COF: begin
        rd_addr.a0 = k_r[0] ? ADJ[i_r][2] : ADJ[i_r][0];
        rd_addr.a1 = k_r[0] ? ADJ[i_r][3] : ADJ[i_r][1];
      end
      PH_DET: begin
        rd_addr.a0 = idx_t'(k_r[2:1]);
        kf_addr    = times3(k_r[2:1]);
      end
      default: begin
        kf_addr = i_r;
      end
    endcase
  end

  // multiplier operands; a cofactor goes in as low and high halves
  always_comb begin
    mul_x = MULW'(signed'(rd_data.a0));
    mul_y = '0;
    unique case (ph_r)
      PH_MUL:  mul_y = MULW'(signed'(rd_data.b));
      PH_COF:  mul_y = MULW'(signed'(rd_data.a1));
      PH_DET:  mul_y = k_r[0] ? signed'(kf_rd_r[KW-1:VW])
                              : signed'({1'b0, kf_rd_r[VW-1:0]});
      default: mul_y = '0;
    endcase
    prod = mul_x * mul_y;
  end

  always_comb begin
    term = ACCW'(prod_r);
    if (ph_r == PH_DET && k_r[0]) term = ACCW'(prod_r) <<< VW;
    if (ph_r == PH_COF && k_r[0]) term = -term;
    last_k  = (ph_r == PH_MUL && k_r == K_MUL_LAST) ||
              (ph_r == PH_COF && k_r == K_COF_LAST) ||
              (ph_r == PH_DET && k_r == K_DET_LAST);
    add_sum = SW'(signed'(rd_data.a0)) + SW'(signed'(rd_data.b));
    div_q   = div_rsp.neg ? -SW'({1'b0, div_rsp.q_mag}) : SW'({1'b0, div_rsp.q_mag});
    kf_we   = (state_r == S_FIN) && (ph_r == PH_COF);
  end

  // cofactor scratch memory
  always_ff @(posedge clk) begin
    if (kf_we) kf_mem[i_r] <= acc_r[KW-1:0];
    kf_rd_r <= kf_mem[kf_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= PH_ADD;
      i_r         <= '0;
      k_r         <= '0;
      sing_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the output once taken, unless a new element loads it
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            unique case (mode)
              MODE_ADD: ph_r <= PH_ADD;
              MODE_MUL: ph_r <= PH_MUL;
              default:  ph_r <= PH_COF;
            endcase
            sing_r  <= 1'b0;
            i_r     <= '0;
            k_r     <= '0;
            acc_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          state_r <= (ph_r == PH_DIV) ? S_DIV : S_MUL;
        end
        S_MUL: begin
          if (ph_r == PH_ADD) begin
            val_r   <= sat_val(add_sum);
            state_r <= S_EMIT;
          end else begin
            prod_r  <= prod;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          acc_r <= acc_r + term;
          if (last_k) begin
            state_r <= S_FIN;
          end else begin
            k_r     <= k_r + 3'd1;
            state_r <= S_RD;
          end
        end
        S_FIN: begin
          k_r   <= '0;
          acc_r <= '0;
          priority case (ph_r)
            PH_MUL: begin
              val_r   <= sat_val(SW'(acc_r >>> FB));
              state_r <= S_EMIT;
            end
            PH_COF: begin
              if (i_r == LAST_IDX) begin
                ph_r <= PH_DET;
                i_r  <= '0;
              end else begin
                i_r <= i_r + 1'b1;
              end
              state_r <= S_RD;
            end
            default: begin
              det_r <= acc_r;
              i_r   <= '0;
              if (acc_r == '0) begin
                ph_r    <= PH_ZERO;
                sing_r  <= 1'b1;
                val_r   <= '0;
                state_r <= S_EMIT;
              end else begin
                ph_r    <= PH_DIV;
                state_r <= S_RD;
              end
            end
          endcase
        end
        S_DIV: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_rsp.done) begin
            val_r   <= sat_val(div_q);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          // load the output register once it is free
          if (!out_valid_r || out_ready) begin
            out_valid_r    <= 1'b1;
            out_r.idx      <= i_r;
            out_r.value    <= val_r;
            out_r.singular <= sing_r;
            out_r.last     <= (i_r == LAST_IDX);
            if (i_r == LAST_IDX) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              k_r     <= '0;
              acc_r   <= '0;
              state_r <= (ph_r == PH_ZERO) ? S_EMIT : S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign idle          = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_res       = out_r;
  assign div_req.start = (state_r == S_DIV);
  assign div_req.num   = ACCW'(kf_rd_r) <<< (2 * FB);
  assign div_req.den   = det_r;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE)
    else $error("operation started while busy");
  a_dwait_det: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DWAIT |-> ph_r == PH_DIV && det_r != '0)
    else $error("division with zero determinant");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DWAIT)
    else $error("divider finished with no waiting element");
  a_kf_range: assert property (@(posedge clk) disable iff (!rst_n)
    kf_we |-> i_r <= LAST_IDX)
    else $error("cofactor write beyond scratch memory");
`endif

endmodule

// File: rtl/matrix_3x3_add_mul_inverse.sv
// Add and multiply compute one result element at a time; multiply runs
// each term through the single shared multiplier after the memory read.
// Invert first forms the cofactors and determinant, then divides each
// element in the bit-serial divider (99 quotient bits). Input is taken
// only while no operation runs. Reset clears control state only; the
// element and cofactor memories are not cleared.
// ----------------------------------------------------------------------------
// matrix_3x3_add_mul_inverse
// 3x3 fixed-point matrix add, multiply and inverse by adjugate.
// ----------------------------------------------------------------------------
module matrix_3x3_add_mul_inverse (
  input  logic     clk,
  input  logic     rst_n,
  m3_in_if.sink    in_ch,
  m3_out_if.source out_ch
);
  import m3_pkg::*;

  logic     idle;
  logic     accept;
  logic     start;
  wr_t      wr;
  rd_addr_t rd_addr;
  rd_data_t rd_data;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;

  // loads land in memory; element 8 with a valid mode starts the operation
  assign in_ch.ready = idle;
  assign accept      = in_ch.valid && idle;
  assign wr.en       = accept && (in_ch.elem_index <= LAST_IDX);
  assign wr.idx      = in_ch.elem_index;
  assign wr.a        = in_ch.a_elem;
  assign wr.b        = in_ch.b_elem;
  assign start       = accept && (in_ch.elem_index == LAST_IDX) &&
                       (mode_t'(in_ch.mode) != MODE_NONE);

  m3_store u_store (
    .clk  (clk),
    .wr   (wr),
    .addr (rd_addr),
    .data (rd_data)
  );

  m3_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  m3_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .mode      (mode_t'(in_ch.mode)),
    .idle      (idle),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.out_index = res.idx;
  assign out_ch.out_value = res.value;
  assign out_ch.singular  = res.singular;
  assign out_ch.last_out  = res.last;

endmodule
